[rtl/sit_pkg.sv]
package sit_pkg;

  // Load enables for the product and difference stages of a cross-product unit.
  typedef struct packed {
    logic prod;
    logic diff;
  } sit_en_t;

  // Two sides straddle the other segment unless both are strictly
  // positive or both strictly negative.
  function automatic logic sit_straddles(input logic neg1, input logic zero1,
                                         input logic neg2, input logic zero2);
    logic pos1;
    logic pos2;
    pos1 = !neg1 && !zero1;
    pos2 = !neg2 && !zero2;
    return !((pos1 && pos2) || (neg1 && neg2));
  endfunction

endpackage

[rtl/sit_if.sv]
interface sit_pts_if #(
  parameter int COORD_WIDTH = 32
);
  logic                          valid;
  logic                          ready;
  logic signed [COORD_WIDTH-1:0] ax;
  logic signed [COORD_WIDTH-1:0] ay;
  logic signed [COORD_WIDTH-1:0] bx;
  logic signed [COORD_WIDTH-1:0] by;
  logic signed [COORD_WIDTH-1:0] cx;
  logic signed [COORD_WIDTH-1:0] cy;
  logic signed [COORD_WIDTH-1:0] dx;
  logic signed [COORD_WIDTH-1:0] dy;

  modport source (output valid, ax, ay, bx, by, cx, cy, dx, dy, input ready);
  modport sink (input valid, ax, ay, bx, by, cx, cy, dx, dy, output ready);
endinterface

interface sit_res_if;
  logic valid;
  logic ready;
  logic intersects;

  modport source (output valid, intersects, input ready);
  modport sink (input valid, intersects, output ready);
endinterface

[rtl/sit_cross.sv]
module sit_cross #(
  parameter int DW = 33
) (
  input  logic                   clk_i,
  input  sit_pkg::sit_en_t       en_i,
  input  logic signed [DW-1:0]   ua_i,
  input  logic signed [DW-1:0]   ub_i,
  input  logic signed [DW-1:0]   uc_i,
  input  logic signed [DW-1:0]   ud_i,
  output logic signed [2*DW:0]   cross_o
);
  import sit_pkg::*;

  localparam int PW = 2 * DW;

  logic signed [PW-1:0] p1_q;
  logic signed [PW-1:0] p2_q;
  logic signed [PW:0]   x_q;

  always_ff @(posedge clk_i) begin
    if (en_i.prod) begin
      p1_q <= PW'(ua_i) * PW'(ub_i);
      p2_q <= PW'(uc_i) * PW'(ud_i);
    end
    if (en_i.diff) begin
      x_q <= (PW + 1)'(p1_q) - (PW + 1)'(p2_q);
    end
  end

  assign cross_o = x_q;

endmodule

[rtl/segment_intersection_test.sv]
// Four-stage pipeline: coordinate differences and interval overlap, products,
// cross-product differences, then the side tests into the output register.
// One pair of segments is accepted every cycle unless the output stalls back to the input,
// and each stage fills independently under a stall.
// rst_ni clears all valid bits asynchronously; data registers are not reset.
module segment_intersection_test #(
  parameter int COORD_WIDTH = 32
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  sit_pts_if.sink   pts_i,
  sit_res_if.source res_o
);
  import sit_pkg::*;

  localparam int DW = COORD_WIDTH + 1;
  localparam int XW = 2 * DW + 1;

  function automatic logic signed [DW-1:0] sub(input logic signed [COORD_WIDTH-1:0] a,
                                               input logic signed [COORD_WIDTH-1:0] b);
    return DW'(a) - DW'(b);
  endfunction

  logic v1_q, v2_q, v3_q, v4_q;
  logic rdy1, rdy2, rdy3, rdy4;
  logic ov1_q, ov2_q, ov3_q;
  logic hit_q;
  logic hit;
  logic ovx, ovy;
  sit_en_t en;

  logic signed [DW-1:0] bax_q, bay_q, cax_q, cay_q, dax_q, day_q;
  logic signed [DW-1:0] dcx_q, dcy_q, acx_q, acy_q, bcx_q, bcy_q;
  logic signed [XW-1:0] abc, abd, cda, cdb;

  assign rdy4 = !v4_q || res_o.ready;
  assign rdy3 = !v3_q || rdy4;
  assign rdy2 = !v2_q || rdy3;
  assign rdy1 = !v1_q || rdy2;
  assign pts_i.ready = rdy1;

  assign en.prod = rdy2;
  assign en.diff = rdy3;

  assign ovx = (((pts_i.ax < pts_i.bx) ? pts_i.ax : pts_i.bx) <=
                ((pts_i.cx < pts_i.dx) ? pts_i.dx : pts_i.cx)) &&
               (((pts_i.cx < pts_i.dx) ? pts_i.cx : pts_i.dx) <=
                ((pts_i.ax < pts_i.bx) ? pts_i.bx : pts_i.ax));
  assign ovy = (((pts_i.ay < pts_i.by) ? pts_i.ay : pts_i.by) <=
                ((pts_i.cy < pts_i.dy) ? pts_i.dy : pts_i.cy)) &&
               (((pts_i.cy < pts_i.dy) ? pts_i.cy : pts_i.dy) <=
                ((pts_i.ay < pts_i.by) ? pts_i.by : pts_i.ay));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
      v4_q <= 1'b0;
    end else begin
      if (rdy1) v1_q <= pts_i.valid;
      if (rdy2) v2_q <= v1_q;
      if (rdy3) v3_q <= v2_q;
      if (rdy4) v4_q <= v3_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (rdy1) begin
      ov1_q <= ovx && ovy;
      bax_q <= sub(pts_i.bx, pts_i.ax);
      bay_q <= sub(pts_i.by, pts_i.ay);
      cax_q <= sub(pts_i.cx, pts_i.ax);
      cay_q <= sub(pts_i.cy, pts_i.ay);
      dax_q <= sub(pts_i.dx, pts_i.ax);
      day_q <= sub(pts_i.dy, pts_i.ay);
      dcx_q <= sub(pts_i.dx, pts_i.cx);
      dcy_q <= sub(pts_i.dy, pts_i.cy);
      acx_q <= sub(pts_i.ax, pts_i.cx);
      acy_q <= sub(pts_i.ay, pts_i.cy);
      bcx_q <= sub(pts_i.bx, pts_i.cx);
      bcy_q <= sub(pts_i.by, pts_i.cy);
    end
    if (rdy2) ov2_q <= ov1_q;
    if (rdy3) ov3_q <= ov2_q;
    if (rdy4) hit_q <= hit;
  end

  sit_cross #(.DW(DW)) u_abc (
    .clk_i(clk_i), .en_i(en), .ua_i(bax_q), .ub_i(cay_q), .uc_i(bay_q), .ud_i(cax_q),
    .cross_o(abc)
  );
  sit_cross #(.DW(DW)) u_abd (
    .clk_i(clk_i), .en_i(en), .ua_i(bax_q), .ub_i(day_q), .uc_i(bay_q), .ud_i(dax_q),
    .cross_o(abd)
  );
  sit_cross #(.DW(DW)) u_cda (
    .clk_i(clk_i), .en_i(en), .ua_i(dcx_q), .ub_i(acy_q), .uc_i(dcy_q), .ud_i(acx_q),
    .cross_o(cda)
  );
  sit_cross #(.DW(DW)) u_cdb (
    .clk_i(clk_i), .en_i(en), .ua_i(dcx_q), .ub_i(bcy_q), .uc_i(dcy_q), .ud_i(bcx_q),
    .cross_o(cdb)
  );

  assign hit = ov3_q &&
               sit_straddles(abc[XW-1], abc == '0, abd[XW-1], abd == '0) &&
               sit_straddles(cda[XW-1], cda == '0, cdb[XW-1], cdb == '0);

  assign res_o.valid      = v4_q;
  assign res_o.intersects = hit_q;

endmodule

[rtl/sit_checker.sv]
module sit_checker (
  input logic clk_i,
  input logic rst_ni,
  input logic in_valid_i,
  input logic in_ready_i,
  input logic out_valid_i,
  input logic out_ready_i,
  input logic out_intersects_i
);
  localparam int Depth = 4;

  logic [2:0] cnt_q;
  logic [2:0] cnt_d;
  logic       in_beat;
  logic       out_beat;

  assign in_beat  = in_valid_i && in_ready_i;
  assign out_beat = out_valid_i && out_ready_i;
  assign cnt_d    = cnt_q + 3'(in_beat) - 3'(out_beat);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
    end else begin
      cnt_q <= cnt_d;
    end
  end

  // A result beat never appears without an item in flight.
  a_no_invented: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i |-> cnt_q != 3'd0)
    else $error("result beat without an accepted input");

  // The pipeline never holds more items than it has stages.
  a_bounded: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= 3'(Depth))
    else $error("more items in flight than pipeline stages");

  // A stalled result stays presented.
  a_hold_valid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i)
    else $error("result dropped while stalled");

  // A stalled result keeps its value.
  a_hold_data: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> $stable(out_intersects_i))
    else $error("result changed while stalled");

endmodule

bind segment_intersection_test sit_checker u_sit_checker (
  .clk_i           (clk_i),
  .rst_ni          (rst_ni),
  .in_valid_i      (pts_i.valid),
  .in_ready_i      (pts_i.ready),
  .out_valid_i     (res_o.valid),
  .out_ready_i     (res_o.ready),
  .out_intersects_i(res_o.intersects)
);

[bench/testbench.sv]
`timescale 1ns / 100ps

module testbench;

  localparam int CW          = 32;
  localparam int N_DIR       = 20;
  localparam int N_PHASES    = 4;
  localparam int PHASE_ITEMS = 333;
  localparam int HOLD_AT     = 100;
  localparam int HOLD_LEN    = 300;
  localparam int DRAIN_WAIT  = 8;

  typedef logic signed [CW-1:0] coord_t;

  localparam coord_t MINC = coord_t'(32'h8000_0000);
  localparam coord_t MAXC = coord_t'(32'h7fff_ffff);

  typedef enum logic [1:0] {SIDE_NEG, SIDE_ZERO, SIDE_POS} side_e;

  typedef struct {
    coord_t ax, ay, bx, by, cx, cy, dx, dy;
  } seg_pair_t;

  typedef struct {
    seg_pair_t s;
    bit        known;
    bit        hit;
  } dir_row_t;

  typedef struct {
    bit hit;
    int idx;
  } hit_exp_t;

  logic clk;
  logic rst_n;

  sit_pts_if #(.COORD_WIDTH(CW)) pts ();
  sit_res_if res ();

  segment_intersection_test #(
    .COORD_WIDTH(CW)
  ) dut (
    .clk_i (clk),
    .rst_ni(rst_n),
    .pts_i (pts),
    .res_o (res)
  );

  hit_exp_t hit_q[$];
  int n_sent;
  int n_got;
  int n_err;
  int phase;
  int src_idle_pct;
  int snk_stall_pct;

  // Rows with known = 0 are checked against the predictor.
  dir_row_t dir_tab [N_DIR] = '{
    '{'{0, 0, 10, 10, 0, 10, 10, 0}, 1'b1, 1'b1},
    '{'{0, 0, 10, 0, 0, 5, 10, 5}, 1'b1, 1'b0},
    '{'{0, 0, 5, 5, 5, 5, 10, 0}, 1'b1, 1'b1},
    '{'{0, 0, 10, 0, 5, 0, 5, 7}, 1'b1, 1'b1},
    '{'{0, 0, 6, 6, 3, 3, 9, 9}, 1'b1, 1'b1},
    '{'{0, 0, 2, 2, 3, 3, 9, 9}, 1'b1, 1'b0},
    '{'{0, 0, 3, 3, 3, 3, 9, 9}, 1'b1, 1'b1},
    '{'{0, 0, 8, 4, 4, 2, 4, 2}, 1'b1, 1'b1},
    '{'{0, 0, 8, 4, 4, 3, 4, 3}, 1'b1, 1'b0},
    '{'{7, -7, 7, -7, 7, -7, 7, -7}, 1'b1, 1'b1},
    '{'{1, 1, 1, 1, 1, 2, 1, 2}, 1'b1, 1'b0},
    '{'{0, 0, 10, 10, 6, 0, 10, 3}, 1'b1, 1'b0},
    '{'{MINC, MINC, MAXC, MAXC, MINC, MAXC, MAXC, MINC}, 1'b1, 1'b1},
    '{'{MINC, MINC, MINC, MINC, MINC, MINC, MINC, MINC}, 1'b1, 1'b1},
    '{'{MAXC, MAXC, MAXC, MAXC, MAXC, MAXC, MAXC, MAXC}, 1'b1, 1'b1},
    '{'{MINC, MINC, MAXC, MAXC, MINC, MAXC, -1, 0}, 1'b0, 1'b0},
    '{'{MAXC, MINC, MINC, MAXC, MAXC, MAXC, 0, 0}, 1'b0, 1'b0},
    '{'{MINC, MINC, MAXC, MAXC, 0, 0, 0, 1}, 1'b0, 1'b0},
    '{'{MINC, MAXC, MAXC, MINC, -1, -1, -1, -1}, 1'b0, 1'b0},
    '{'{-1, -1, 0, 0, -1, 0, 0, -1}, 1'b1, 1'b1}
  };

  function automatic side_e side_of(coord_t px, coord_t py, coord_t qx, coord_t qy,
                                    coord_t rx, coord_t ry);
    logic signed [71:0] ex, ey, fx, fy, cr;
    ex = qx - px;
    ey = qy - py;
    fx = rx - px;
    fy = ry - py;
    cr = ex * fy - ey * fx;
    if (cr == 0) return SIDE_ZERO;
    return cr < 0 ? SIDE_NEG : SIDE_POS;
  endfunction

  function automatic bit spans_meet(coord_t a, coord_t b, coord_t c, coord_t d);
    coord_t lo, hi;
    lo = (a < b) ? a : b;
    if (((c < d) ? c : d) > lo) lo = (c < d) ? c : d;
    hi = (a > b) ? a : b;
    if (((c > d) ? c : d) < hi) hi = (c > d) ? c : d;
    return lo <= hi;
  endfunction

  function automatic bit straddles(side_e s1, side_e s2);
    return !((s1 == SIDE_POS && s2 == SIDE_POS) || (s1 == SIDE_NEG && s2 == SIDE_NEG));
  endfunction

  function automatic bit seg_hit(seg_pair_t s);
    return spans_meet(s.ax, s.bx, s.cx, s.dx) && spans_meet(s.ay, s.by, s.cy, s.dy) &&
           straddles(side_of(s.ax, s.ay, s.bx, s.by, s.cx, s.cy),
                     side_of(s.ax, s.ay, s.bx, s.by, s.dx, s.dy)) &&
           straddles(side_of(s.cx, s.cy, s.dx, s.dy, s.ax, s.ay),
                     side_of(s.cx, s.cy, s.dx, s.dy, s.bx, s.by));
  endfunction

  function automatic coord_t grid_coord();
    return coord_t'(int'($urandom_range(16)) - 8);
  endfunction

  function automatic coord_t extreme_coord();
    case ($urandom_range(6))
      0: return MINC;
      1: return MAXC;
      2: return MINC + 1;
      3: return MAXC - 1;
      4: return -1;
      5: return 1;
      default: return 0;
    endcase
  endfunction

  task automatic send_seg(seg_pair_t s, bit known, bit hit);
    hit_exp_t e;
    while ($urandom_range(99) < src_idle_pct) begin
      pts.valid <= 1'b0;
      @(posedge clk);
    end
    pts.valid <= 1'b1;
    pts.ax    <= s.ax;
    pts.ay    <= s.ay;
    pts.bx    <= s.bx;
    pts.by    <= s.by;
    pts.cx    <= s.cx;
    pts.cy    <= s.cy;
    pts.dx    <= s.dx;
    pts.dy    <= s.dy;
    do @(posedge clk); while (!pts.ready);
    e.hit = known ? hit : seg_hit(s);
    e.idx = n_sent;
    hit_q.push_back(e);
    n_sent++;
  endtask

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  // Result beats are checked and the output ready is paced here.
  initial begin : result_side
    hit_exp_t e;
    int hold_left;
    bit held;
    hold_left = 0;
    held = 1'b0;
    res.ready = 1'b0;
    forever begin
      @(posedge clk);
      if (res.valid && res.ready) begin
        if (hit_q.size() == 0) begin
          $error("unexpected result beat: intersects %0b", res.intersects);
          n_err++;
        end else begin
          e = hit_q.pop_front();
          if (res.intersects !== e.hit) begin
            $error("pair %0d: intersects expected %0b, actual %0b",
                   e.idx, e.hit, res.intersects);
            n_err++;
          end
        end
        n_got++;
      end
      if (!held && phase == 0 && n_got >= HOLD_AT) begin
        held = 1'b1;
        hold_left = HOLD_LEN;
      end
      if (hold_left > 0) begin
        res.ready <= 1'b0;
        hold_left--;
      end else begin
        res.ready <= ($urandom_range(99) >= snk_stall_pct);
      end
    end
  end

  initial begin
    #2_000_000;
    $error("timeout with %0d results outstanding", hit_q.size());
    $display("DONE: errors detected");
    $finish;
  end

  initial begin : stimulus
    seg_pair_t s;
    int i, ph, sh, ux, uy;
    coord_t px, py;
    int t0, t1, t2, t3;
    n_sent = 0;
    n_got = 0;
    n_err = 0;
    phase = 0;
    src_idle_pct = 0;
    snk_stall_pct = 0;
    rst_n = 1'b0;
    pts.valid = 1'b0;
    pts.ax = '0;
    pts.ay = '0;
    pts.bx = '0;
    pts.by = '0;
    pts.cx = '0;
    pts.cy = '0;
    pts.dx = '0;
    pts.dy = '0;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    for (i = 0; i < N_DIR; i++) begin
      send_seg(dir_tab[i].s, dir_tab[i].known, dir_tab[i].hit);
    end
    pts.valid <= 1'b0;
    wait (hit_q.size() == 0);
    @(posedge clk);

    for (ph = 0; ph < N_PHASES; ph++) begin
      phase = ph;
      src_idle_pct  = (ph == 1) ? 75 : (ph == 3) ? 23 : 0;
      snk_stall_pct = (ph == 2) ? 75 : (ph == 3) ? 23 : 0;
      for (i = 0; i < PHASE_ITEMS; i++) begin
        case ($urandom_range(9))
          0, 1: begin
            s = '{coord_t'($urandom), coord_t'($urandom), coord_t'($urandom),
                  coord_t'($urandom), coord_t'($urandom), coord_t'($urandom),
                  coord_t'($urandom), coord_t'($urandom)};
          end
          2, 3: begin
            s = '{grid_coord(), grid_coord(), grid_coord(), grid_coord(),
                  grid_coord(), grid_coord(), grid_coord(), grid_coord()};
          end
          4: begin
            s = '{extreme_coord(), extreme_coord(), extreme_coord(), extreme_coord(),
                  extreme_coord(), extreme_coord(), extreme_coord(), extreme_coord()};
          end
          5: begin
            sh = $urandom_range(31);
            s = '{coord_t'($urandom) >>> sh, coord_t'($urandom) >>> sh,
                  coord_t'($urandom) >>> sh, coord_t'($urandom) >>> sh,
                  coord_t'($urandom) >>> sh, coord_t'($urandom) >>> sh,
                  coord_t'($urandom) >>> sh, coord_t'($urandom) >>> sh};
            case ($urandom_range(3))
              0: begin s.cx = s.ax; s.cy = s.ay; end
              1: begin s.cx = s.bx; s.cy = s.by; end
              2: begin s.dx = s.ax; s.dy = s.ay; end
              default: begin s.dx = s.bx; s.dy = s.by; end
            endcase
          end
          6: begin
            px = coord_t'($urandom) >>> 10;
            py = coord_t'($urandom) >>> 10;
            ux = int'($urandom_range(6)) - 3;
            uy = int'($urandom_range(6)) - 3;
            t0 = int'($urandom_range(8)) - 4;
            t1 = int'($urandom_range(8)) - 4;
            t2 = int'($urandom_range(8)) - 4;
            t3 = int'($urandom_range(8)) - 4;
            s = '{px + t0 * ux, py + t0 * uy, px + t1 * ux, py + t1 * uy,
                  px + t2 * ux, py + t2 * uy, px + t3 * ux, py + t3 * uy};
          end
          7: begin
            s = '{grid_coord(), grid_coord(), grid_coord(), grid_coord(),
                  grid_coord(), grid_coord(), 0, 0};
            s.dx = s.cx;
            s.dy = s.cy;
            if ($urandom_range(1)) begin
              s.bx = s.ax;
              s.by = s.ay;
            end
          end
          default: begin
            px = coord_t'($urandom) >>> 2;
            py = coord_t'($urandom) >>> 2;
            sh = $urandom_range(30, 2);
            s = '{px + (coord_t'($urandom) >>> sh), py + (coord_t'($urandom) >>> sh),
                  px + (coord_t'($urandom) >>> sh), py + (coord_t'($urandom) >>> sh),
                  px + (coord_t'($urandom) >>> sh), py + (coord_t'($urandom) >>> sh),
                  px + (coord_t'($urandom) >>> sh), py + (coord_t'($urandom) >>> sh)};
          end
        endcase
        send_seg(s, 1'b0, 1'b0);
      end
      pts.valid <= 1'b0;
      wait (hit_q.size() == 0);
      @(posedge clk);
    end

    repeat (DRAIN_WAIT) @(posedge clk);
    $display("Sent %0d segment pairs (%0d directed) under %0d pacing phases.",
             n_sent, N_DIR, N_PHASES);
    $display("Compared %0d result beats, with one long output stall and input drains.",
             n_got);
    if (n_err == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule
